// ----- hw/rtl/stxetx_pkg.sv -----
package stxetx_pkg;

  localparam int unsigned BufferBytes = 65536;
  localparam int unsigned CapBytes    = (BufferBytes < 16) ? 16 :
                                        (BufferBytes > 65536) ? 65536 : BufferBytes;
  localparam int unsigned FrameOverhead = 9;
  localparam int unsigned CapLimit    = CapBytes - FrameOverhead;

  localparam logic [7:0]  StxByte = 8'h02;
  localparam logic [7:0]  EtxByte = 8'h03;
  localparam logic [15:0] MaxPayloadReset = 16'd65527;

  localparam logic [0:0] CfgDialect    = 1'b0;
  localparam logic [0:0] CfgMaxPayload = 1'b1;

  localparam logic DialectAscii  = 1'b0;
  localparam logic DialectBinary = 1'b1;

  typedef enum logic [2:0] {
    StHunt   = 3'd0,
    StInside = 3'd1,
    StGood   = 3'd2,
    StCsum   = 3'd3,
    StLen    = 3'd4,
    StOver   = 3'd5
  } status_e;

  typedef struct packed {
    status_e     byte_status;
    logic [15:0] frame_pos;
    logic [7:0]  data_byte;
  } result_t;

endpackage

// ----- hw/rtl/stxetx_frame_fsm.sv -----
module stxetx_frame_fsm (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [0:0]           cfg_idx_i,
  input  logic [15:0]          cfg_wdata_i,
  input  logic                 step_i,
  input  logic [7:0]           rx_byte_i,
  output stxetx_pkg::result_t  result_o
);

  localparam logic [16:0] Cap17   = 17'(stxetx_pkg::CapBytes);
  localparam logic [15:0] CapLim  = 16'(stxetx_pkg::CapLimit);

  logic        dialect_q;
  logic [15:0] max_pay_q;
  logic        coll_q, coll_d;
  logic [15:0] cnt_q, cnt_d;
  logic [1:0]  magic_q, magic_d;
  logic [31:0] len_q, len_d;
  logic [7:0]  xor_q, xor_d;
  logic [15:0] limit;
  logic [31:0] len_shift;
  logic [32:0] len_end;
  stxetx_pkg::status_e st;
  logic [15:0] pos;

  assign limit     = (max_pay_q < CapLim) ? max_pay_q : CapLim;
  assign len_shift = {len_q[23:0], rx_byte_i};
  assign len_end   = {1'b0, len_q} + 33'd8;

  always_comb begin
    coll_d  = coll_q;
    cnt_d   = cnt_q;
    magic_d = magic_q;
    len_d   = len_q;
    xor_d   = xor_q;
    st      = stxetx_pkg::StHunt;
    pos     = 16'd0;
    if (dialect_q == stxetx_pkg::DialectAscii) begin
      if (!coll_q) begin
        if (rx_byte_i == stxetx_pkg::StxByte) begin
          coll_d = 1'b1;
          cnt_d  = 16'd1;
          st     = stxetx_pkg::StInside;
        end
      end else begin
        pos = cnt_q;
        if (rx_byte_i == stxetx_pkg::EtxByte) begin
          st     = stxetx_pkg::StGood;
          coll_d = 1'b0;
          cnt_d  = '0;
          magic_d = '0;
          len_d  = '0;
          xor_d  = '0;
        end else if ({1'b0, cnt_q} + 17'd1 >= Cap17) begin
          st     = stxetx_pkg::StOver;
          coll_d = 1'b0;
          cnt_d  = '0;
          magic_d = '0;
          len_d  = '0;
          xor_d  = '0;
        end else begin
          cnt_d = cnt_q + 16'd1;
          st    = stxetx_pkg::StInside;
        end
      end
    end else begin
      if (!coll_q) begin
        if (rx_byte_i == stxetx_pkg::StxByte) begin
          if (magic_q == 2'd3) begin
            coll_d  = 1'b1;
            cnt_d   = 16'd4;
            magic_d = '0;
            len_d   = '0;
            xor_d   = '0;
            pos     = 16'd3;
            st      = stxetx_pkg::StInside;
          end else begin
            magic_d = magic_q + 2'd1;
          end
        end else begin
          magic_d = '0;
        end
      end else begin
        pos = cnt_q;
        if (cnt_q < 16'd8) begin
          len_d = len_shift;
          cnt_d = cnt_q + 16'd1;
          st    = stxetx_pkg::StInside;
          if (cnt_q == 16'd7 && len_shift > {16'd0, limit}) begin
            st      = stxetx_pkg::StLen;
            coll_d  = 1'b0;
            cnt_d   = '0;
            magic_d = '0;
            len_d   = '0;
            xor_d   = '0;
          end
        end else if ({17'd0, cnt_q} < len_end) begin
          xor_d = xor_q ^ rx_byte_i;
          cnt_d = cnt_q + 16'd1;
          st    = stxetx_pkg::StInside;
        end else begin
          st      = (rx_byte_i == xor_q) ? stxetx_pkg::StGood : stxetx_pkg::StCsum;
          coll_d  = 1'b0;
          cnt_d   = '0;
          magic_d = '0;
          len_d   = '0;
          xor_d   = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dialect_q <= stxetx_pkg::DialectAscii;
      max_pay_q <= stxetx_pkg::MaxPayloadReset;
      coll_q    <= 1'b0;
      cnt_q     <= '0;
      magic_q   <= '0;
      len_q     <= '0;
      xor_q     <= '0;
    end else if (cfg_we_i && cfg_idx_i == stxetx_pkg::CfgDialect) begin
      dialect_q <= cfg_wdata_i[0];
      coll_q    <= 1'b0;
      cnt_q     <= '0;
      magic_q   <= '0;
      len_q     <= '0;
      xor_q     <= '0;
    end else begin
      if (cfg_we_i && cfg_idx_i == stxetx_pkg::CfgMaxPayload) begin
        max_pay_q <= cfg_wdata_i;
      end
      if (step_i) begin
        coll_q  <= coll_d;
        cnt_q   <= cnt_d;
        magic_q <= magic_d;
        len_q   <= len_d;
        xor_q   <= xor_d;
      end
    end
  end

  assign result_o.data_byte   = rx_byte_i;
  assign result_o.frame_pos   = pos;
  assign result_o.byte_status = st;

  a_cnt_zero_when_hunting: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !coll_q |-> (cnt_q == 16'd0 && len_q == 32'd0 && xor_q == 8'd0))
    else $error("framing counters not clear while hunting");

  a_cnt_nonzero_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    coll_q |-> cnt_q != 16'd0)
    else $error("frame open with zero position");

  a_binary_frame_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (coll_q && dialect_q == stxetx_pkg::DialectBinary) |-> (cnt_q >= 16'd4 && magic_q == 2'd0))
    else $error("binary frame state inconsistent");

  a_len_bounded_after_header: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (coll_q && dialect_q == stxetx_pkg::DialectBinary && cnt_q >= 16'd8) |->
      len_q[31:16] == 16'd0)
    else $error("accepted payload length out of range");

endmodule

// ----- hw/rtl/stxetx_out_reg.sv -----
module stxetx_out_reg (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  output logic                 ready_o,
  input  stxetx_pkg::result_t  result_i,
  output logic                 valid_o,
  input  logic                 ready_i,
  output stxetx_pkg::result_t  result_o
);

  logic                valid_q;
  stxetx_pkg::result_t result_q;

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      result_q <= result_i;
    end
  end

  assign valid_o  = valid_q;
  assign result_o = result_q;

endmodule

// ----- hw/rtl/stx_etx_and_length_xor_deframer.sv -----
// Channel   Dir  Payload (low bit up)                                    Accepted when
// s_axis    in   tdata[7:0] rx_byte                                      tvalid && tready
// m_axis    out  tdata[7:0] data_byte, [23:8] frame_pos,                 tvalid && tready
//                [26:24] byte_status, [31:27] zero
// cfg       in   cfg_idx_i 0 dialect, 1 max_payload; cfg_wdata_i         cfg_we_i high
//
// Each request passes an input register, then the framing logic into an output register.
// A result leaves through the output register; one request per cycle while m_axis does
// not stall, and the framing logic updates its state once for each request it takes.
// Reset clears the framing state and loads dialect 0 and max_payload 65527.
// When m_axis stalls, the output register holds, and once the input register is also
// full it holds too and s_axis_tready drops.
module stx_etx_and_length_xor_deframer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [7:0] data_byte, [23:8] frame_pos, [26:24] byte_status
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i
);

  logic                in_valid_q;
  logic [7:0]          in_byte_q;
  logic                out_ready;
  logic                step;
  stxetx_pkg::result_t res_d;
  stxetx_pkg::result_t res_q;

  assign step          = in_valid_q && out_ready;
  assign s_axis_tready = !in_valid_q || out_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte_q <= s_axis_tdata;
    end
  end

  stxetx_frame_fsm u_fsm (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .step_i      (step),
    .rx_byte_i   (in_byte_q),
    .result_o    (res_d)
  );

  stxetx_out_reg u_out (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (in_valid_q),
    .ready_o  (out_ready),
    .result_i (res_d),
    .valid_o  (m_axis_tvalid),
    .ready_i  (m_axis_tready),
    .result_o (res_q)
  );

  assign m_axis_tdata = {5'd0, res_q};

endmodule
